>>> rtl/core/rpsv_pkg.sv
// rpsv_pkg: shared types and constants of the read pair sv classifier
// no dependencies; used by the channel interfaces and all rtl/core modules

package rpsv_pkg;

   // fixed field widths
   localparam int CHROM_W   = 16;
   localparam int POS_W     = 31;
   localparam int QUAL_W    = 8;
   localparam int WEIGHT_W  = 16;
   localparam int OUT_W     = 32;
   localparam int PDATA_W   = 32;
   localparam int PADDR_W   = 5;
   localparam int REG_IDX_W = 3;

   // configuration register indexes (byte address is 4 times the index)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_BP_REACH      = 3'd0,
      REG_INTERVAL_SIZE = 3'd1,
      REG_MIN_UNSHARED  = 3'd2,
      REG_MIN_QUALITY   = 3'd3,
      REG_SPAN_UPPER    = 3'd4,
      REG_SPAN_LOWER    = 3'd5
   } reg_idx_type;

   // sv type codes
   typedef enum logic [1:0] {
      SV_DELETION    = 2'd0,
      SV_DUPLICATION = 2'd1,
      SV_INVERSION   = 2'd2
   } sv_code_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [15:0]        bp_reach;
      logic [16:0]        interval_size;
      logic [15:0]        min_unshared;
      logic [QUAL_W-1:0]  min_quality;
      logic signed [31:0] span_upper;
      logic signed [31:0] span_lower;
   } cfg_type;

   // one request: a mapped read pair
   typedef struct packed {
      logic [CHROM_W-1:0]  chrom_rank_a;
      logic [POS_W-1:0]    start_a;
      logic [POS_W-1:0]    end_a;
      logic                minus_a;
      logic [QUAL_W-1:0]   quality_a;
      logic [CHROM_W-1:0]  chrom_rank_b;
      logic [POS_W-1:0]    start_b;
      logic [POS_W-1:0]    end_b;
      logic                minus_b;
      logic [QUAL_W-1:0]   quality_b;
      logic [WEIGHT_W-1:0] weight_in;
   } req_type;

   // one result
   typedef struct packed {
      logic                  keep;
      logic [1:0]            sv_type;
      logic [CHROM_W-1:0]    left_chrom;
      logic signed [OUT_W-1:0] left_bp_start;
      logic signed [OUT_W-1:0] left_bp_end;
      logic                  left_minus;
      logic [CHROM_W-1:0]    right_chrom;
      logic signed [OUT_W-1:0] right_bp_start;
      logic signed [OUT_W-1:0] right_bp_end;
      logic                  right_minus;
      logic [WEIGHT_W-1:0]   weight_out;
   } rsp_type;

endpackage

>>> rtl/core/rpsv_req_if.sv
// rpsv_req_if: request channel (valid, ready, read pair payload)
// depends on rpsv_pkg for field widths

interface rpsv_req_if;
   logic                             valid;
   logic                             ready;
   logic [rpsv_pkg::CHROM_W-1:0]     chrom_rank_a;
   logic [rpsv_pkg::POS_W-1:0]       start_a;
   logic [rpsv_pkg::POS_W-1:0]       end_a;
   logic                             minus_a;
   logic [rpsv_pkg::QUAL_W-1:0]      quality_a;
   logic [rpsv_pkg::CHROM_W-1:0]     chrom_rank_b;
   logic [rpsv_pkg::POS_W-1:0]       start_b;
   logic [rpsv_pkg::POS_W-1:0]       end_b;
   logic                             minus_b;
   logic [rpsv_pkg::QUAL_W-1:0]      quality_b;
   logic [rpsv_pkg::WEIGHT_W-1:0]    weight_in;

   modport source (
      output valid, chrom_rank_a, start_a, end_a, minus_a, quality_a,
             chrom_rank_b, start_b, end_b, minus_b, quality_b, weight_in,
      input  ready
   );
   modport sink (
      input  valid, chrom_rank_a, start_a, end_a, minus_a, quality_a,
             chrom_rank_b, start_b, end_b, minus_b, quality_b, weight_in,
      output ready
   );
endinterface

>>> rtl/core/rpsv_rsp_if.sv
// rpsv_rsp_if: result channel (valid, ready, classification payload)
// depends on rpsv_pkg for field widths

interface rpsv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  keep;
   logic [1:0]                            sv_type;
   logic [rpsv_pkg::CHROM_W-1:0]          left_chrom;
   logic signed [rpsv_pkg::OUT_W-1:0]     left_bp_start;
   logic signed [rpsv_pkg::OUT_W-1:0]     left_bp_end;
   logic                                  left_minus;
   logic [rpsv_pkg::CHROM_W-1:0]          right_chrom;
   logic signed [rpsv_pkg::OUT_W-1:0]     right_bp_start;
   logic signed [rpsv_pkg::OUT_W-1:0]     right_bp_end;
   logic                                  right_minus;
   logic [rpsv_pkg::WEIGHT_W-1:0]         weight_out;

   modport source (
      output valid, keep, sv_type, left_chrom, left_bp_start, left_bp_end, left_minus,
             right_chrom, right_bp_start, right_bp_end, right_minus, weight_out,
      input  ready
   );
   modport sink (
      input  valid, keep, sv_type, left_chrom, left_bp_start, left_bp_end, left_minus,
             right_chrom, right_bp_start, right_bp_end, right_minus, weight_out,
      output ready
   );
endinterface

>>> rtl/core/rpsv_csr.sv
// rpsv_csr: apb-style configuration registers of the classifier
// depends on rpsv_pkg (cfg_type, register indexes)

module rpsv_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rpsv_pkg::PADDR_W-1:0]  paddr,
   input  logic [rpsv_pkg::PDATA_W-1:0]  pwdata,
   output logic [rpsv_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output rpsv_pkg::cfg_type             cfg
);

   rpsv_pkg::cfg_type     cfg_ff;
   rpsv_pkg::cfg_type     cfg_in;
   rpsv_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign pready = 1'b1;
   assign idx    = rpsv_pkg::reg_idx_type'(paddr[rpsv_pkg::PADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            rpsv_pkg::REG_BP_REACH:      cfg_in.bp_reach      = pwdata[15:0];
            rpsv_pkg::REG_INTERVAL_SIZE: cfg_in.interval_size = pwdata[16:0];
            rpsv_pkg::REG_MIN_UNSHARED:  cfg_in.min_unshared  = pwdata[15:0];
            rpsv_pkg::REG_MIN_QUALITY:   cfg_in.min_quality   = pwdata[7:0];
            rpsv_pkg::REG_SPAN_UPPER:    cfg_in.span_upper    = $signed(pwdata);
            rpsv_pkg::REG_SPAN_LOWER:    cfg_in.span_lower    = $signed(pwdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         rpsv_pkg::REG_BP_REACH:      prdata = {16'd0, cfg_ff.bp_reach};
         rpsv_pkg::REG_INTERVAL_SIZE: prdata = {15'd0, cfg_ff.interval_size};
         rpsv_pkg::REG_MIN_UNSHARED:  prdata = {16'd0, cfg_ff.min_unshared};
         rpsv_pkg::REG_MIN_QUALITY:   prdata = {24'd0, cfg_ff.min_quality};
         rpsv_pkg::REG_SPAN_UPPER:    prdata = cfg_ff.span_upper;
         rpsv_pkg::REG_SPAN_LOWER:    prdata = cfg_ff.span_lower;
         default:                     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/rpsv_classify.sv
// rpsv_classify: combinational classification of one registered read pair
// depends on rpsv_pkg (req_type, rsp_type, cfg_type, sv codes)

module rpsv_classify #(
   parameter int COORD_BITS = 32
) (
   input  rpsv_pkg::req_type req,
   input  rpsv_pkg::cfg_type cfg,
   output rpsv_pkg::rsp_type rsp
);

   localparam int CB = COORD_BITS;
   localparam int SW = (COORD_BITS > 32) ? COORD_BITS : 32;

   typedef struct packed {
      logic [rpsv_pkg::CHROM_W-1:0] chrom;
      logic [CB-1:0]                first;
      logic [CB-1:0]                last;
      logic                         minus;
   } read_type;

   typedef struct packed {
      logic [CB-1:0] bs;
      logic [CB-1:0] be;
   } bp_type;

   // breakpoint interval of one read, wrapping at CB bits
   function automatic bp_type bp_interval(input read_type r, input logic [CB-1:0] bd,
                                          input logic [CB-1:0] isz);
      bp_type res;
      if (!r.minus) begin
         res.bs = r.last - bd;
         res.be = res.bs + isz - CB'(1);
      end else begin
         res.be = r.first + bd;
         res.bs = res.be - isz + CB'(1);
      end
      return res;
   endfunction

   read_type          a, b, l, r;
   logic [rpsv_pkg::QUAL_W-1:0] qmin;
   logic [CB-1:0]     len_l, len_r, mn_end, mx_st, overlap, mn_len, non_ov, non_ov_abs;
   logic [CB-1:0]     span;
   logic signed [SW-1:0] span_x, up_x, lo_x;
   logic              sane, aberrant;
   logic [CB-1:0]     bd_x, isz_x;
   bp_type            lbp, rbp;

   always_comb begin
      // unpack reads, last base is one-past end minus one
      a.chrom = req.chrom_rank_a;
      a.first = CB'(req.start_a);
      a.last  = CB'(req.end_a) - CB'(1);
      a.minus = req.minus_a;
      b.chrom = req.chrom_rank_b;
      b.first = CB'(req.start_b);
      b.last  = CB'(req.end_b) - CB'(1);
      b.minus = req.minus_b;

      // order: greater rank left, else smaller start left, a on a tie
      if (a.chrom > b.chrom) begin
         l = a; r = b;
      end else if (a.chrom < b.chrom) begin
         l = b; r = a;
      end else if ($signed(a.first) > $signed(b.first)) begin
         l = b; r = a;
      end else begin
         l = a; r = b;
      end

      // sanity: quality and non-overlap
      qmin    = (req.quality_a < req.quality_b) ? req.quality_a : req.quality_b;
      len_l   = l.last - l.first;
      len_r   = r.last - r.first;
      mn_end  = ($signed(l.last) < $signed(r.last)) ? l.last : r.last;
      mx_st   = ($signed(l.first) > $signed(r.first)) ? l.first : r.first;
      overlap = mn_end - mx_st;
      mn_len  = ($signed(len_l) < $signed(len_r)) ? len_l : len_r;
      non_ov  = mn_len - overlap;
      non_ov_abs = ($signed(non_ov) < 0) ? (CB'(0) - non_ov) : non_ov;
      sane = (qmin >= cfg.min_quality);
      if (($signed(overlap) > 0) &&
          ($signed(non_ov_abs) < $signed(CB'(cfg.min_unshared)))) begin
         sane = 1'b0;
      end

      // aberrance: equal strands, minus-strand left read, or span outside thresholds
      span   = r.last - l.first;
      span_x = SW'($signed(span));
      up_x   = SW'($signed(cfg.span_upper));
      lo_x   = SW'($signed(cfg.span_lower));
      aberrant = (l.minus == r.minus) || l.minus || (span_x >= up_x) || (span_x <= lo_x);

      // breakpoint intervals
      bd_x  = CB'(cfg.bp_reach);
      isz_x = CB'(cfg.interval_size);
      lbp   = bp_interval(l, bd_x, isz_x);
      rbp   = bp_interval(r, bd_x, isz_x);

      // result
      rsp.keep = sane && aberrant;
      if (l.minus == r.minus) begin
         rsp.sv_type = rpsv_pkg::SV_INVERSION;
      end else if (!l.minus) begin
         rsp.sv_type = rpsv_pkg::SV_DELETION;
      end else begin
         rsp.sv_type = rpsv_pkg::SV_DUPLICATION;
      end
      rsp.left_chrom     = l.chrom;
      rsp.left_bp_start  = rpsv_pkg::OUT_W'($signed(lbp.bs));
      rsp.left_bp_end    = rpsv_pkg::OUT_W'($signed(lbp.be));
      rsp.left_minus     = l.minus;
      rsp.right_chrom    = r.chrom;
      rsp.right_bp_start = rpsv_pkg::OUT_W'($signed(rbp.bs));
      rsp.right_bp_end   = rpsv_pkg::OUT_W'($signed(rbp.be));
      rsp.right_minus    = r.minus;
      rsp.weight_out     = req.weight_in;
   end

endmodule

>>> rtl/core/read_pair_sv_classifier_top.sv
// read_pair_sv_classifier_top: read pair sv classifier, input register, logic, result register
// depends on rpsv_pkg, rpsv_req_if, rpsv_rsp_if, rpsv_csr, rpsv_classify
//
//   channel   direction  handshake           payload
//   req_chan  in         valid/ready         one mapped read pair and weight
//   rsp_chan  out        valid/ready         keep, sv type, two intervals, weight
//   apb       in         psel/penable/pready six configuration registers
//
// one request per cycle sustained while rsp is not stalled; an accepted request is held in the
// input register, classified, and rsp valid rises once it moves into the result register.
// reset is synchronous and active high: valid flags and configuration registers clear,
// the payload registers are not reset.
// a stalled result holds in the result register while the input register still
// fills; req ready drops only when both registers are occupied and rsp is stalled.

module read_pair_sv_classifier_top #(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   rpsv_req_if.sink                      req_chan,
   rpsv_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rpsv_pkg::PADDR_W-1:0]  paddr,
   input  logic [rpsv_pkg::PDATA_W-1:0]  pwdata,
   output logic [rpsv_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   rpsv_pkg::cfg_type cfg;
   rpsv_pkg::req_type req_ff, req_in;
   rpsv_pkg::rsp_type rsp_ff, rsp_in;
   logic              in_vld_ff, in_vld_in;
   logic              out_vld_ff, out_vld_in;
   logic              adv;

   // configuration registers
   rpsv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pipeline control
   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !in_vld_ff || adv;

   always_comb begin
      in_vld_in  = req_chan.ready ? req_chan.valid : in_vld_ff;
      out_vld_in = adv ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input register payload
   always_comb begin
      req_in = req_ff;
      if (req_chan.ready && req_chan.valid) begin
         req_in.chrom_rank_a = req_chan.chrom_rank_a;
         req_in.start_a      = req_chan.start_a;
         req_in.end_a        = req_chan.end_a;
         req_in.minus_a      = req_chan.minus_a;
         req_in.quality_a    = req_chan.quality_a;
         req_in.chrom_rank_b = req_chan.chrom_rank_b;
         req_in.start_b      = req_chan.start_b;
         req_in.end_b        = req_chan.end_b;
         req_in.minus_b      = req_chan.minus_b;
         req_in.quality_b    = req_chan.quality_b;
         req_in.weight_in    = req_chan.weight_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // classification logic
   rpsv_pkg::rsp_type cls;

   rpsv_classify #(
      .COORD_BITS (COORD_BITS)
   ) u_classify (
      .req (req_ff),
      .cfg (cfg),
      .rsp (cls)
   );

   // result register payload
   always_comb begin
      rsp_in = (adv && in_vld_ff) ? cls : rsp_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // result channel
   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.keep           = rsp_ff.keep;
   assign rsp_chan.sv_type        = rsp_ff.sv_type;
   assign rsp_chan.left_chrom     = rsp_ff.left_chrom;
   assign rsp_chan.left_bp_start  = rsp_ff.left_bp_start;
   assign rsp_chan.left_bp_end    = rsp_ff.left_bp_end;
   assign rsp_chan.left_minus     = rsp_ff.left_minus;
   assign rsp_chan.right_chrom    = rsp_ff.right_chrom;
   assign rsp_chan.right_bp_start = rsp_ff.right_bp_start;
   assign rsp_chan.right_bp_end   = rsp_ff.right_bp_end;
   assign rsp_chan.right_minus    = rsp_ff.right_minus;
   assign rsp_chan.weight_out     = rsp_ff.weight_out;

   // checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> in_vld_ff)
      else $error("accepted request not held in input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff && out_vld_ff)
      else $error("stalled request lost");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !in_vld_ff |=> !rsp_chan.valid)
      else $error("result appeared without a request");

   a_inv_strands: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.sv_type == rpsv_pkg::SV_INVERSION)
         |-> (rsp_chan.left_minus == rsp_chan.right_minus))
      else $error("inversion with differing strands");

endmodule

>>> verif/rpsv_classify_checker.sv
// rpsv_classify_checker: watches the request, result and apb ports of the read pair
// classifier, predicts every classification and compares it field by field
// depends on rpsv_pkg, rpsv_req_if and rpsv_rsp_if
`timescale 1ns / 100ps

module rpsv_classify_checker (
   input  logic                          clock,
   input  logic                          reset,
   rpsv_req_if                           req_mon,
   rpsv_rsp_if                           rsp_mon,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rpsv_pkg::PADDR_W-1:0]  paddr,
   input  logic [rpsv_pkg::PDATA_W-1:0]  pwdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            pending,
   output int                            pairs_checked,
   output int                            pairs_kept
);

   localparam int REPORT_LIMIT = 10;

   // one read after its end has been turned into a last base
   typedef struct {
      logic [rpsv_pkg::CHROM_W-1:0] chrom;
      logic [31:0]                  first_base;
      logic [31:0]                  last_base;
      logic                         minus;
   } aligned_read_type;

   // local copy of the configuration registers
   logic [15:0]                 back_dist;
   logic [16:0]                 ival_size;
   logic [15:0]                 min_nonov;
   logic [rpsv_pkg::QUAL_W-1:0] min_qual;
   logic signed [31:0]          span_hi;
   logic signed [31:0]          span_lo;

   rpsv_pkg::rsp_type predicted_classes[$];

   // count a failure, print only the first few
   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%t checker: %s", $realtime, msg);
   endfunction

   function automatic void field_mismatch(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
      log_failure($sformatf("result %0d field %s: expected %h, got %h",
                            pairs_checked, name, want_v, got_v));
   endfunction

   // breakpoint interval of one read, 32-bit wrapping
   function automatic void breakpoint_window(input aligned_read_type rd,
                                             output logic [31:0] bs, output logic [31:0] be);
      if (!rd.minus) begin
         bs = rd.last_base - 32'(back_dist);
         be = bs + 32'(ival_size) - 32'd1;
      end else begin
         be = rd.first_base + 32'(back_dist);
         bs = be - 32'(ival_size) + 32'd1;
      end
   endfunction

   // full classification of one read pair
   function automatic rpsv_pkg::rsp_type classify_pair(input rpsv_pkg::req_type p);
      aligned_read_type ra, rb, lf, rt;
      logic [rpsv_pkg::QUAL_W-1:0] qmin;
      logic [31:0] len_l, len_r, mn_end, mx_st, overlap, mn_len, non_ov, span;
      logic [31:0] lbs, lbe, rbs, rbe;
      logic sane, aberrant;
      rpsv_pkg::sv_code_type sv;
      rpsv_pkg::rsp_type o;

      ra.chrom = p.chrom_rank_a;
      ra.first_base = {1'b0, p.start_a};
      ra.last_base = {1'b0, p.end_a} - 32'd1;
      ra.minus = p.minus_a;
      rb.chrom = p.chrom_rank_b;
      rb.first_base = {1'b0, p.start_b};
      rb.last_base = {1'b0, p.end_b} - 32'd1;
      rb.minus = p.minus_b;

      // left read: greater chromosome rank, else smaller start, read a on a tie
      if (ra.chrom > rb.chrom) begin
         lf = ra; rt = rb;
      end else if (ra.chrom < rb.chrom) begin
         lf = rb; rt = ra;
      end else if ($signed(ra.first_base) > $signed(rb.first_base)) begin
         lf = rb; rt = ra;
      end else begin
         lf = ra; rt = rb;
      end

      // sanity: weaker quality and non-overlap of overlapping reads
      qmin = (p.quality_a < p.quality_b) ? p.quality_a : p.quality_b;
      sane = (qmin >= min_qual);
      len_l = lf.last_base - lf.first_base;
      len_r = rt.last_base - rt.first_base;
      mn_end = ($signed(lf.last_base) < $signed(rt.last_base)) ? lf.last_base : rt.last_base;
      mx_st = ($signed(lf.first_base) > $signed(rt.first_base)) ? lf.first_base
                                                                 : rt.first_base;
      overlap = mn_end - mx_st;
      mn_len = ($signed(len_l) < $signed(len_r)) ? len_l : len_r;
      non_ov = mn_len - overlap;
      if ($signed(non_ov) < 0)
         non_ov = 32'd0 - non_ov;
      if ($signed(overlap) > 0 && $signed(non_ov) < $signed({16'h0, min_nonov}))
         sane = 1'b0;

      // aberrance: strands, left strand, span thresholds
      span = rt.last_base - lf.first_base;
      aberrant = (lf.minus == rt.minus) || lf.minus ||
                 ($signed(span) >= span_hi) || ($signed(span) <= span_lo);

      breakpoint_window(lf, lbs, lbe);
      breakpoint_window(rt, rbs, rbe);

      if (lf.minus == rt.minus)
         sv = rpsv_pkg::SV_INVERSION;
      else if (!lf.minus)
         sv = rpsv_pkg::SV_DELETION;
      else
         sv = rpsv_pkg::SV_DUPLICATION;

      o.keep = sane && aberrant;
      o.sv_type = sv;
      o.left_chrom = lf.chrom;
      o.left_bp_start = lbs;
      o.left_bp_end = lbe;
      o.left_minus = lf.minus;
      o.right_chrom = rt.chrom;
      o.right_bp_start = rbs;
      o.right_bp_end = rbe;
      o.right_minus = rt.minus;
      o.weight_out = p.weight_in;
      return o;
   endfunction

   // sample all three ports at the rising edge
   always @(posedge clock) begin : watch_ports
      rpsv_pkg::req_type req_seen;
      rpsv_pkg::rsp_type got, want;

      if (reset) begin
         back_dist = '0;
         ival_size = '0;
         min_nonov = '0;
         min_qual = '0;
         span_hi = '0;
         span_lo = '0;
         predicted_classes.delete();
         fail_count = 0;
         pending = 0;
         pairs_checked = 0;
         pairs_kept = 0;
      end else begin
         // accepted request: predict its classification
         if (req_mon.valid && req_mon.ready) begin
            req_seen.chrom_rank_a = req_mon.chrom_rank_a;
            req_seen.start_a = req_mon.start_a;
            req_seen.end_a = req_mon.end_a;
            req_seen.minus_a = req_mon.minus_a;
            req_seen.quality_a = req_mon.quality_a;
            req_seen.chrom_rank_b = req_mon.chrom_rank_b;
            req_seen.start_b = req_mon.start_b;
            req_seen.end_b = req_mon.end_b;
            req_seen.minus_b = req_mon.minus_b;
            req_seen.quality_b = req_mon.quality_b;
            req_seen.weight_in = req_mon.weight_in;
            predicted_classes.push_back(classify_pair(req_seen));
         end

         // accepted result: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.keep = rsp_mon.keep;
            got.sv_type = rsp_mon.sv_type;
            got.left_chrom = rsp_mon.left_chrom;
            got.left_bp_start = rsp_mon.left_bp_start;
            got.left_bp_end = rsp_mon.left_bp_end;
            got.left_minus = rsp_mon.left_minus;
            got.right_chrom = rsp_mon.right_chrom;
            got.right_bp_start = rsp_mon.right_bp_start;
            got.right_bp_end = rsp_mon.right_bp_end;
            got.right_minus = rsp_mon.right_minus;
            got.weight_out = rsp_mon.weight_out;
            if (predicted_classes.size() == 0) begin
               log_failure("result arrived with no request outstanding");
            end else begin
               want = predicted_classes.pop_front();
               if (got.keep !== want.keep)
                  field_mismatch("keep", want.keep, got.keep);
               if (got.sv_type !== want.sv_type)
                  field_mismatch("sv_type", want.sv_type, got.sv_type);
               if (got.left_chrom !== want.left_chrom)
                  field_mismatch("left_chrom", want.left_chrom, got.left_chrom);
               if (got.left_bp_start !== want.left_bp_start)
                  field_mismatch("left_bp_start", want.left_bp_start, got.left_bp_start);
               if (got.left_bp_end !== want.left_bp_end)
                  field_mismatch("left_bp_end", want.left_bp_end, got.left_bp_end);
               if (got.left_minus !== want.left_minus)
                  field_mismatch("left_minus", want.left_minus, got.left_minus);
               if (got.right_chrom !== want.right_chrom)
                  field_mismatch("right_chrom", want.right_chrom, got.right_chrom);
               if (got.right_bp_start !== want.right_bp_start)
                  field_mismatch("right_bp_start", want.right_bp_start, got.right_bp_start);
               if (got.right_bp_end !== want.right_bp_end)
                  field_mismatch("right_bp_end", want.right_bp_end, got.right_bp_end);
               if (got.right_minus !== want.right_minus)
                  field_mismatch("right_minus", want.right_minus, got.right_minus);
               if (got.weight_out !== want.weight_out)
                  field_mismatch("weight_out", want.weight_out, got.weight_out);
               if (want.keep)
                  pairs_kept++;
            end
            pairs_checked++;
         end

         // register write completes at this edge, unlisted indexes are dropped
         if (psel && penable && pwrite && pready) begin
            case (paddr[rpsv_pkg::PADDR_W-1:2])
               rpsv_pkg::REG_BP_REACH:      back_dist = pwdata[15:0];
               rpsv_pkg::REG_INTERVAL_SIZE: ival_size = pwdata[16:0];
               rpsv_pkg::REG_MIN_UNSHARED:  min_nonov = pwdata[15:0];
               rpsv_pkg::REG_MIN_QUALITY:   min_qual = pwdata[rpsv_pkg::QUAL_W-1:0];
               rpsv_pkg::REG_SPAN_UPPER:    span_hi = pwdata[31:0];
               rpsv_pkg::REG_SPAN_LOWER:    span_lo = pwdata[31:0];
               default: ;
            endcase
         end

         pending = predicted_classes.size();
      end
   end

endmodule

>>> verif/read_pair_sv_classifier_top_test.sv
// read_pair_sv_classifier_top_test: drives directed and random read pairs and
// register settings into the classifier with bursty requests and a stalling receiver
// depends on rpsv_pkg, rpsv_req_if, rpsv_rsp_if, read_pair_sv_classifier_top, rpsv_classify_checker
`timescale 1ns / 100ps

module read_pair_sv_classifier_top_test;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES    = 6;
   localparam int PAIRS_PER_PHASE  = 300;
   localparam int DRAIN_CYCLES     = 4;
   localparam logic [rpsv_pkg::REG_IDX_W-1:0] UNLISTED_REG = 3'd6;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [rpsv_pkg::PADDR_W-1:0] paddr;
   logic [rpsv_pkg::PDATA_W-1:0] pwdata;
   logic [rpsv_pkg::PDATA_W-1:0] prdata;
   logic                         pready;
   logic                         hold_off_req;

   int fail_count;
   int pending;
   int pairs_checked;
   int pairs_kept;
   int pairs_sent = 0;
   int settings_used = 0;

   rpsv_req_if req_chan ();
   rpsv_rsp_if rsp_chan ();

   read_pair_sv_classifier_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   rpsv_classify_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending       (pending),
      .pairs_checked (pairs_checked),
      .pairs_kept    (pairs_kept)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   initial begin : run_limit
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random ready pattern, one long hold-off once asked for
   initial begin : rsp_stall_pattern
      int seg_len;
      int mode;
      logic hold_off_done;
      logic rdy;
      hold_off_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            seg_len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++) begin
               case (mode)
                  0: rdy = 1'b1;
                  1: rdy = ($urandom_range(0, 3) != 0);
                  2: rdy = ($urandom_range(0, 3) == 0);
                  default: rdy = k[0];
               endcase
               rsp_chan.ready <= rdy;
               @(posedge clock);
            end
         end
      end
   end

   function automatic rpsv_pkg::cfg_type make_settings(input int back, input int isize,
                                                       input int nonov, input int minq,
                                                       input int upper, input int lower);
      rpsv_pkg::cfg_type c;
      c.bp_reach = 16'(back);
      c.interval_size = 17'(isize);
      c.min_unshared = 16'(nonov);
      c.min_quality = 8'(minq);
      c.span_upper = upper;
      c.span_lower = lower;
      return c;
   endfunction

   // register settings for the random phases
   function automatic rpsv_pkg::cfg_type pick_settings(input int flavor);
      int lower;
      lower = $urandom_range(0, 400);
      case (flavor)
         0, 1: return make_settings($urandom_range(0, 300), $urandom_range(1, 1000),
                                    $urandom_range(0, 100), $urandom_range(0, 60),
                                    lower + $urandom_range(100, 1500), lower);
         2:    return make_settings(65535, 131071, 65535, 255, 32'h7FFF_FFFF, 32'h8000_0000);
         3:    return make_settings(0, 0, 0, 0, 0, 0);
         4:    return make_settings(65535, 0, $urandom_range(0, 100), $urandom_range(0, 60),
                                    lower + $urandom_range(100, 1500), lower);
         default: return make_settings($urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
      endcase
   endfunction

   function automatic rpsv_pkg::req_type read_pair(input int ca, input int sa, input int ea,
                                                   input int ma, input int qa, input int cb,
                                                   input int sb, input int eb, input int mb,
                                                   input int qb, input int w);
      rpsv_pkg::req_type p;
      p.chrom_rank_a = 16'(ca);
      p.start_a = 31'(sa);
      p.end_a = 31'(ea);
      p.minus_a = ma[0];
      p.quality_a = 8'(qa);
      p.chrom_rank_b = 16'(cb);
      p.start_b = 31'(sb);
      p.end_b = 31'(eb);
      p.minus_b = mb[0];
      p.quality_b = 8'(qb);
      p.weight_in = 16'(w);
      return p;
   endfunction

   // mostly plausible pairs around the span window, some pure noise
   function automatic rpsv_pkg::req_type random_pair(input int mid);
      rpsv_pkg::req_type p;
      logic [31:0] pos, s2;
      int len1, len2, offset, shape;
      shape = $urandom_range(0, 15);
      if (shape < 2)
         return read_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 7))
         0:       pos = $urandom_range(0, 4000);
         1:       pos = $urandom_range(32'h7FFF_F000, 32'h7FFF_FFFF);
         default: pos = $urandom_range(0, 32'h7FFF_0000);
      endcase
      len1 = $urandom_range(1, 300);
      len2 = $urandom_range(1, 300);
      // empty or reversed read now and then
      if (shape == 2)
         len1 = -int'($urandom_range(0, 200));
      offset = int'($urandom_range(0, 2 * mid + 400)) - 200;
      if ($urandom_range(0, 1))
         offset = -offset;
      s2 = pos + offset;
      p.chrom_rank_a = 16'($urandom);
      p.chrom_rank_b = ($urandom_range(0, 3) != 0) ? p.chrom_rank_a : 16'($urandom);
      p.start_a = pos[30:0];
      p.end_a = 31'(pos + len1);
      p.start_b = s2[30:0];
      p.end_b = 31'(s2 + len2);
      p.minus_a = 1'($urandom_range(0, 1));
      p.minus_b = 1'($urandom_range(0, 1));
      p.quality_a = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(20, 255));
      p.quality_b = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(20, 255));
      p.weight_in = 16'($urandom);
      return p;
   endfunction

   // offer one request, hold until accepted
   task automatic push_pair(input rpsv_pkg::req_type p);
      req_chan.valid <= 1'b1;
      req_chan.chrom_rank_a <= p.chrom_rank_a;
      req_chan.start_a <= p.start_a;
      req_chan.end_a <= p.end_a;
      req_chan.minus_a <= p.minus_a;
      req_chan.quality_a <= p.quality_a;
      req_chan.chrom_rank_b <= p.chrom_rank_b;
      req_chan.start_b <= p.start_b;
      req_chan.end_b <= p.end_b;
      req_chan.minus_b <= p.minus_b;
      req_chan.quality_b <= p.quality_b;
      req_chan.weight_in <= p.weight_in;
      do @(posedge clock); while (!req_chan.ready);
      pairs_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup phase, access phase until pready, then the bus goes idle
   task automatic csr_write(input logic [rpsv_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input rpsv_pkg::cfg_type c);
      csr_write(rpsv_pkg::REG_BP_REACH, 32'(c.bp_reach));
      csr_write(rpsv_pkg::REG_INTERVAL_SIZE, 32'(c.interval_size));
      csr_write(rpsv_pkg::REG_MIN_UNSHARED, 32'(c.min_unshared));
      csr_write(rpsv_pkg::REG_MIN_QUALITY, 32'(c.min_quality));
      csr_write(rpsv_pkg::REG_SPAN_UPPER, c.span_upper);
      csr_write(rpsv_pkg::REG_SPAN_LOWER, c.span_lower);
      settings_used++;
   endtask

   // bursts of requests with random gaps
   task automatic send_random_pairs(input int count, input int mid);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            push_pair(random_pair(mid));
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      rpsv_pkg::cfg_type cfg;
      int mid;

      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      hold_off_req <= 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.chrom_rank_a <= '0;
      req_chan.start_a <= '0;
      req_chan.end_a <= '0;
      req_chan.minus_a <= 1'b0;
      req_chan.quality_a <= '0;
      req_chan.chrom_rank_b <= '0;
      req_chan.start_b <= '0;
      req_chan.end_b <= '0;
      req_chan.minus_b <= 1'b0;
      req_chan.quality_b <= '0;
      req_chan.weight_in <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset values: all-zero and all-ones pairs
      push_pair(read_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      push_pair(read_pair(65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 255,
                          65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 255, 65535));
      drain_results();

      // typical thresholds: each sv type, ordering rules, sanity and span cases
      apply_settings(make_settings(50, 200, 20, 30, 600, 100));
      push_pair(read_pair(5, 1000, 1100, 0, 60, 5, 1400, 1500, 1, 60, 1));
      push_pair(read_pair(5, 1000, 1100, 0, 60, 5, 5000, 5100, 1, 60, 2));
      push_pair(read_pair(5, 1000, 1100, 0, 60, 5, 1050, 1090, 1, 60, 3));
      push_pair(read_pair(5, 1000, 1200, 0, 60, 5, 1150, 1400, 0, 60, 4));
      push_pair(read_pair(5, 1000, 1100, 1, 60, 5, 3000, 3100, 0, 60, 5));
      push_pair(read_pair(5, 1000, 1100, 1, 60, 5, 3000, 3100, 1, 60, 6));
      push_pair(read_pair(9, 5000, 5100, 0, 60, 3, 100, 200, 1, 60, 7));
      push_pair(read_pair(3, 5000, 5100, 0, 60, 9, 100, 200, 1, 60, 8));
      push_pair(read_pair(7, 9000, 9100, 1, 60, 7, 2000, 2100, 0, 60, 9));
      push_pair(read_pair(7, 4000, 4100, 0, 60, 7, 4000, 4150, 1, 60, 10));
      push_pair(read_pair(5, 1000, 1100, 0, 10, 5, 5000, 5100, 1, 255, 11));
      push_pair(read_pair(5, 1000, 1100, 0, 30, 5, 5000, 5100, 1, 40, 12));
      // reversed read and empty read
      push_pair(read_pair(5, 2000, 1500, 0, 60, 5, 6000, 6100, 1, 60, 13));
      push_pair(read_pair(5, 0, 0, 0, 60, 5, 700, 800, 1, 60, 14));
      push_pair(read_pair(1, 123, 456, 0, 99, 1, 789, 1000, 1, 99, 65535));
      drain_results();

      // maximum registers, intervals wrap at both ends, unlisted index ignored
      apply_settings(make_settings(65535, 131071, 65535, 255, 32'h7FFF_FFFF, 32'h8000_0000));
      csr_write(UNLISTED_REG, 32'hFFFF_FFFF);
      push_pair(read_pair(0, 0, 10, 0, 255, 0, 50, 60, 1, 255, 100));
      push_pair(read_pair(65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 255,
                          65534, 2147483000, 2147483600, 0, 255, 101));
      push_pair(read_pair(4, 100, 200, 1, 254, 4, 300, 400, 1, 255, 102));
      drain_results();

      // zero interval size, span exactly on each threshold and one inside
      apply_settings(make_settings(0, 0, 0, 0, 500, 100));
      push_pair(read_pair(2, 1000, 1100, 0, 0, 2, 1400, 1501, 1, 0, 200));
      push_pair(read_pair(2, 1000, 1100, 0, 0, 2, 1400, 1500, 1, 0, 201));
      push_pair(read_pair(2, 1000, 1100, 0, 0, 2, 1050, 1101, 1, 0, 202));
      push_pair(read_pair(2, 1000, 1100, 0, 0, 2, 1050, 1102, 1, 0, 203));
      push_pair(read_pair(2, 1000, 1100, 1, 0, 2, 1400, 1500, 1, 0, 204));
      drain_results();

      // random phases, the first one with a long receiver hold-off
      hold_off_req <= 1'b1;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         cfg = pick_settings(phase);
         apply_settings(cfg);
         if (cfg.span_lower >= 0 && cfg.span_upper > cfg.span_lower &&
             cfg.span_upper < 100000)
            mid = (cfg.span_lower + cfg.span_upper) / 2;
         else
            mid = 500;
         send_random_pairs(PAIRS_PER_PHASE, mid);
         drain_results();
      end

      @(negedge clock);
      $display("sent %0d read pairs under %0d register settings", pairs_sent, settings_used);
      $display("checked %0d classifications, %0d of them kept", pairs_checked, pairs_kept);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> read_pair_sv_classifier_top.f
rtl/core/rpsv_pkg.sv
rtl/core/rpsv_req_if.sv
rtl/core/rpsv_rsp_if.sv
rtl/core/rpsv_csr.sv
rtl/core/rpsv_classify.sv
rtl/core/read_pair_sv_classifier_top.sv
verif/rpsv_classify_checker.sv
verif/read_pair_sv_classifier_top_test.sv
